[design/aabb_pkg.sv]
// Shared types and constants for the box overlap and collision normal block.
// Holds the coordinate width, the item structs and the normal direction codes.
// Has no dependencies.
`default_nettype none

package aabb_pkg;

  localparam int CoordBits = 16;
  localparam int SizeBits  = CoordBits - 1;
  localparam int DeltaBits = CoordBits + 1;

  typedef enum logic [2:0] {
    NORMAL_NONE  = 3'd0,
    NORMAL_UP    = 3'd1,
    NORMAL_DOWN  = 3'd2,
    NORMAL_LEFT  = 3'd3,
    NORMAL_RIGHT = 3'd4
  } normal_dir_e;

  typedef struct packed {
    logic signed [CoordBits-1:0] a_x;
    logic signed [CoordBits-1:0] a_y;
    logic        [SizeBits-1:0]  a_w;
    logic        [SizeBits-1:0]  a_h;
    logic signed [CoordBits-1:0] b_x;
    logic signed [CoordBits-1:0] b_y;
    logic        [SizeBits-1:0]  b_w;
    logic        [SizeBits-1:0]  b_h;
  } box_pair_t;

  typedef struct packed {
    logic [DeltaBits-1:0] delta_x;
    logic [DeltaBits-1:0] delta_y;
    logic [2:0]           normal_dir;
  } collision_t;

endpackage

`default_nettype wire

[design/aabb_collision_normal_top.sv]
// Overlap test and collision normal for two axis-aligned boxes.
// Depends on aabb_pkg for the coordinate width, item structs and normal codes.
`default_nettype none

// Each input item is a pair of boxes given as top-left position and size; each
// accepted item yields exactly one result item with the corner deltas and the
// collision normal, or zeros and no normal when the boxes do not overlap. The
// block is a four-stage pipeline: bounds and doubled-center distances, absolute
// values, corner selection, and the normal decision. One item enters per cycle
// while in_stall_o is low, and its result leaves from the normal decision
// register after passing through each stage in order. Each stage holds its item
// independently, so bubbles close up and the input keeps accepting while a
// finished result waits, until all four stages are full.
module aabb_collision_normal_top (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   in_valid_i,
  output logic                  in_stall_o,
  input  aabb_pkg::box_pair_t   in_item_i,
  output logic                  out_valid_o,
  input  wire                   out_stall_i,
  output aabb_pkg::collision_t  out_item_o
);

  localparam int CW = aabb_pkg::CoordBits;
  localparam int DW = CW + 3;
  localparam int GW = CW + 2;
  localparam int OW = aabb_pkg::DeltaBits;

  function automatic logic [DW-2:0] abs_wide(logic signed [DW-1:0] v);
    logic signed [DW-1:0] n;
    n = -v;
    return v[DW-1] ? n[DW-2:0] : v[DW-2:0];
  endfunction

  function automatic logic [GW-2:0] abs_gap(logic signed [GW-1:0] v);
    logic signed [GW-1:0] n;
    n = -v;
    return v[GW-1] ? n[GW-2:0] : v[GW-2:0];
  endfunction

  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4 = !v4_q || !out_stall_i;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign in_stall_o = !rdy1;

  // Stage 1 operands.
  logic signed [DW-1:0] ax_e, ay_e, aw_e, ah_e, bx_e, by_e, bw_e, bh_e;
  logic signed [DW-1:0] dl_d, dr_d, dt_d, db_d;
  logic signed [GW-1:0] gl_w, gr_w, gt_w, gb_w;
  logic                 hit_d;

  always_comb begin
    ax_e = DW'(in_item_i.a_x);
    ay_e = DW'(in_item_i.a_y);
    bx_e = DW'(in_item_i.b_x);
    by_e = DW'(in_item_i.b_y);
    aw_e = DW'($signed({1'b0, in_item_i.a_w}));
    ah_e = DW'($signed({1'b0, in_item_i.a_h}));
    bw_e = DW'($signed({1'b0, in_item_i.b_w}));
    bh_e = DW'($signed({1'b0, in_item_i.b_h}));
    hit_d = (ax_e >= bx_e - aw_e) && (ax_e <= bx_e + bw_e) &&
            (ay_e >= by_e - ah_e) && (ay_e <= by_e + bh_e);
    dl_d = (ax_e <<< 1) - (bx_e <<< 1) - bw_e;
    dr_d = dl_d + (aw_e <<< 1);
    dt_d = (ay_e <<< 1) - (by_e <<< 1) - bh_e;
    db_d = dt_d + (ah_e <<< 1);
    gr_w = GW'(ax_e + aw_e - bx_e);
    gl_w = GW'(ax_e - bx_e - bw_e);
    gb_w = GW'(ay_e + ah_e - by_e);
    gt_w = GW'(ay_e - by_e - bh_e);
  end

  logic                 hit1_q;
  logic signed [DW-1:0] dl_q, dr_q, dt_q, db_q;
  logic signed [GW-1:0] gl_q, gr_q, gt_q, gb_q;

  // Stage 2 results.
  logic          hit2_q;
  logic [DW-2:0] adl_q, adr_q, adt_q, adb_q;
  logic [GW-2:0] agl_q, agr_q, agt_q, agb_q;

  // Stage 3 results.
  logic          hit3_q, right3_q, bottom3_q;
  logic [OW-1:0] dx3_q, dy3_q;

  logic                 right_d, bottom_d;
  aabb_pkg::collision_t res_d, res_q;

  always_comb begin
    right_d  = adr_q < adl_q;
    bottom_d = adb_q < adt_q;
    res_d    = '0;
    if (hit3_q) begin
      res_d.delta_x = dx3_q;
      res_d.delta_y = dy3_q;
      if (dx3_q > dy3_q) begin
        res_d.normal_dir = bottom3_q ? aabb_pkg::NORMAL_DOWN : aabb_pkg::NORMAL_UP;
      end else begin
        res_d.normal_dir = right3_q ? aabb_pkg::NORMAL_RIGHT : aabb_pkg::NORMAL_LEFT;
      end
    end else begin
      res_d.normal_dir = aabb_pkg::NORMAL_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) begin
      hit1_q <= hit_d;
      dl_q   <= dl_d;
      dr_q   <= dr_d;
      dt_q   <= dt_d;
      db_q   <= db_d;
      gl_q   <= gl_w;
      gr_q   <= gr_w;
      gt_q   <= gt_w;
      gb_q   <= gb_w;
    end
    if (rdy2 && v1_q) begin
      hit2_q <= hit1_q;
      adl_q  <= abs_wide(dl_q);
      adr_q  <= abs_wide(dr_q);
      adt_q  <= abs_wide(dt_q);
      adb_q  <= abs_wide(db_q);
      agl_q  <= abs_gap(gl_q);
      agr_q  <= abs_gap(gr_q);
      agt_q  <= abs_gap(gt_q);
      agb_q  <= abs_gap(gb_q);
    end
    if (rdy3 && v2_q) begin
      hit3_q    <= hit2_q;
      right3_q  <= right_d;
      bottom3_q <= bottom_d;
      dx3_q     <= right_d ? agr_q : agl_q;
      dy3_q     <= bottom_d ? agb_q : agt_q;
    end
    if (rdy4 && v3_q) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = v4_q;
  assign out_item_o  = res_q;

endmodule

`default_nettype wire

[verif/aabb_collision_normal_top_tb.sv]
// Self-checking testbench for aabb_collision_normal_top: directed and random box pairs
// go through a valid/stall driver, and every result is compared with a local prediction.
// Depends on aabb_pkg for the item structs, widths and normal direction codes.
module aabb_collision_normal_top_tb;

  logic                 clk_i   = 1'b0;
  logic                 rst_ni  = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall_o;
  aabb_pkg::box_pair_t  in_item = '0;
  logic                 out_valid_o;
  logic                 out_stall = 1'b0;
  aabb_pkg::collision_t out_item_o;

  aabb_pkg::box_pair_t  pending_pairs[$];
  aabb_pkg::collision_t expected_collisions[$];
  aabb_pkg::collision_t want;
  int         mismatch_count = 0;
  int         accepted_count = 0;
  bit         in_fire = 1'b0;
  int         idle_left = 0;
  int         send_calm = 0;
  int         stall_left = 0;
  int         recv_calm = 0;
  int         hold_left = 0;
  bit         hold_done = 1'b0;

  aabb_collision_normal_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_item_o  (out_item_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic longint mag(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  // The x and y corner choices are independent: right and bottom win only when
  // strictly nearer to the doubled center of box B.
  function automatic aabb_pkg::collision_t predict_collision(input aabb_pkg::box_pair_t p);
    longint ax, ay, aw, ah, bx, by, bw, bh;
    longint cx2, cy2, cax, cay, cbx, cby, dx, dy;
    bit right, bottom;
    aabb_pkg::collision_t r;
    ax = longint'($signed(p.a_x));
    ay = longint'($signed(p.a_y));
    bx = longint'($signed(p.b_x));
    by = longint'($signed(p.b_y));
    aw = longint'(p.a_w);
    ah = longint'(p.a_h);
    bw = longint'(p.b_w);
    bh = longint'(p.b_h);
    r = '0;
    r.normal_dir = aabb_pkg::NORMAL_NONE;
    if (ax >= bx - aw && ay >= by - ah && ax <= bx + bw && ay <= by + bh) begin
      cx2 = 2 * bx + bw;
      cy2 = 2 * by + bh;
      right  = mag(2 * (ax + aw) - cx2) < mag(2 * ax - cx2);
      bottom = mag(2 * (ay + ah) - cy2) < mag(2 * ay - cy2);
      cax = right ? ax + aw : ax;
      cay = bottom ? ay + ah : ay;
      cbx = right ? bx : bx + bw;
      cby = bottom ? by : by + bh;
      dx = mag(cax - cbx);
      dy = mag(cay - cby);
      r.delta_x = aabb_pkg::DeltaBits'(dx);
      r.delta_y = aabb_pkg::DeltaBits'(dy);
      if (dx > dy) begin
        r.normal_dir = bottom ? aabb_pkg::NORMAL_DOWN : aabb_pkg::NORMAL_UP;
      end else begin
        r.normal_dir = right ? aabb_pkg::NORMAL_RIGHT : aabb_pkg::NORMAL_LEFT;
      end
    end
    return r;
  endfunction

  function automatic aabb_pkg::box_pair_t make_pair(
      input int ax, input int ay, input int aw, input int ah,
      input int bx, input int by, input int bw, input int bh);
    aabb_pkg::box_pair_t p;
    p.a_x = aabb_pkg::CoordBits'(ax);
    p.a_y = aabb_pkg::CoordBits'(ay);
    p.a_w = aabb_pkg::SizeBits'(aw);
    p.a_h = aabb_pkg::SizeBits'(ah);
    p.b_x = aabb_pkg::CoordBits'(bx);
    p.b_y = aabb_pkg::CoordBits'(by);
    p.b_w = aabb_pkg::SizeBits'(bw);
    p.b_h = aabb_pkg::SizeBits'(bh);
    return p;
  endfunction

  function automatic int rand_size();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 30) return $urandom_range(0, 16);
    if (sel < 80) return $urandom_range(0, 2000);
    return $urandom_range(0, 32767);
  endfunction

  function automatic int rand_coord();
    if ($urandom_range(0, 1) == 0) return int'($urandom_range(0, 8192)) - 4096;
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  // Mostly overlapping pairs with random geometry, plus pairs at independent random positions and raw noise.
  function automatic aabb_pkg::box_pair_t random_pair();
    aabb_pkg::box_pair_t p;
    int sel, ax, ay, aw, ah, bw, bh, ox, oy;
    sel = $urandom_range(0, 99);
    if (sel < 20) begin
      p = aabb_pkg::box_pair_t'($bits(aabb_pkg::box_pair_t)'(
            {$urandom, $urandom, $urandom, $urandom}));
    end else begin
      ax = rand_coord();
      ay = rand_coord();
      aw = rand_size();
      ah = rand_size();
      bw = rand_size();
      bh = rand_size();
      if (sel < 85) begin
        ox = int'($urandom_range(0, aw + bw)) - bw;
        oy = int'($urandom_range(0, ah + bh)) - bh;
        p = make_pair(ax, ay, aw, ah, ax + ox, ay + oy, bw, bh);
      end else begin
        p = make_pair(ax, ay, aw, ah, rand_coord(), rand_coord(), bw, bh);
      end
    end
    return p;
  endfunction

  function automatic int pick_idle(inout int calm);
    int sel;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    sel = $urandom_range(0, 99);
    if (sel < 5) begin
      calm = $urandom_range(20, 60);
      return 0;
    end
    if (sel < 55) return 0;
    if (sel < 93) return $urandom_range(1, 3);
    return $urandom_range(4, 25);
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("mismatch: %s", msg);
  endtask

  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid || in_fire)) begin
      if (idle_left > 0) begin
        in_valid <= 1'b0;
        idle_left--;
      end else if (pending_pairs.size() > 0) begin
        in_item  <= pending_pairs.pop_front();
        in_valid <= 1'b1;
        idle_left = pick_idle(send_calm);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // One long hold-off lets the pipeline fill while the sender keeps offering items.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (!hold_done && accepted_count >= 300) begin
        hold_done = 1'b1;
        hold_left = 400;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        stall_left = pick_idle(recv_calm);
      end
    end
  end

  always @(posedge clk_i) begin
    in_fire = 1'b0;
    if (rst_ni) begin
      if (in_valid && !in_stall_o) begin
        in_fire = 1'b1;
        accepted_count++;
        expected_collisions.push_back(predict_collision(in_item));
      end
      if (out_valid_o && !out_stall) begin
        if (expected_collisions.size() == 0) begin
          report_mismatch("result arrived with no expectation waiting");
        end else begin
          want = expected_collisions.pop_front();
          if (out_item_o.delta_x !== want.delta_x)
            report_mismatch($sformatf("delta_x got %0d want %0d",
                                      out_item_o.delta_x, want.delta_x));
          if (out_item_o.delta_y !== want.delta_y)
            report_mismatch($sformatf("delta_y got %0d want %0d",
                                      out_item_o.delta_y, want.delta_y));
          if (out_item_o.normal_dir !== want.normal_dir)
            report_mismatch($sformatf("normal_dir got %0d want %0d",
                                      out_item_o.normal_dir, want.normal_dir));
        end
      end
    end
  end

  initial begin
    pending_pairs.push_back(make_pair(0, 0, 10, 10, 20, 0, 5, 5));
    pending_pairs.push_back(make_pair(0, 0, 10, 10, 0, 11, 5, 5));
    pending_pairs.push_back(make_pair(0, 0, 10, 10, 10, 0, 5, 5));
    pending_pairs.push_back(make_pair(-10, 0, 10, 10, 0, 0, 5, 5));
    pending_pairs.push_back(make_pair(0, 0, 10, 10, 0, 10, 5, 5));
    pending_pairs.push_back(make_pair(0, -10, 10, 10, 0, 0, 5, 5));
    pending_pairs.push_back(make_pair(5, 5, 0, 0, 5, 5, 0, 0));
    pending_pairs.push_back(make_pair(5, 5, 0, 0, 0, 0, 10, 10));
    pending_pairs.push_back(make_pair(0, 0, 10, 10, 2, 2, 6, 6));
    pending_pairs.push_back(make_pair(0, 0, 10, 10, 5, 5, 10, 10));
    pending_pairs.push_back(make_pair(0, 0, 20, 4, 15, 2, 10, 10));
    pending_pairs.push_back(make_pair(0, 0, 20, 4, 15, -8, 10, 10));
    pending_pairs.push_back(make_pair(0, 0, 4, 20, 2, 15, 10, 10));
    pending_pairs.push_back(make_pair(0, 0, 4, 20, -8, 15, 10, 10));
    pending_pairs.push_back(make_pair(-32768, -32768, 32767, 32767,
                                      32767, 32767, 32767, 32767));
    pending_pairs.push_back(make_pair(-32768, -32768, 32767, 32767,
                                      -32768, -32768, 32767, 32767));
    pending_pairs.push_back(make_pair(32767, 32767, 32767, 32767, 32767, 32767, 0, 0));
    pending_pairs.push_back(make_pair(32767, 0, 32767, 32767, 0, 0, 32767, 32767));
    pending_pairs.push_back(make_pair(-32768, 32767, 0, 32767, -32768, 32767, 32767, 0));
    pending_pairs.push_back(make_pair(-1, -1, 32767, 32767, -1, -1, 32767, 32767));
    pending_pairs.push_back(make_pair(0, 0, 0, 0, 0, 0, 0, 0));
    pending_pairs.push_back(make_pair(-32768, -32768, 0, 0, 32767, 32767, 0, 0));
    repeat (800) pending_pairs.push_back(random_pair());

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    while (pending_pairs.size() > 0 || in_valid || expected_collisions.size() > 0)
      @(negedge clk_i);
    repeat (10) @(negedge clk_i);
    if (mismatch_count == 0) begin
      $display("[aabb_collision_normal_top] OK");
    end else begin
      $display("[aabb_collision_normal_top] ERROR");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("[aabb_collision_normal_top] ERROR");
    $finish;
  end

endmodule
